FILE: src/keypad_debounce_pin_entry_assert.svh
// Assertion macros for the keypad poller.
// KPD_ASSERT_IMP: same-cycle implication, KPD_ASSERT_NXT: next-cycle implication.
`ifndef KEYPAD_DEBOUNCE_PIN_ENTRY_ASSERT_SVH
`define KEYPAD_DEBOUNCE_PIN_ENTRY_ASSERT_SVH
`ifndef ASSERT_OFF
`define KPD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("keypad poller: implication check failed");
`define KPD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("keypad poller: next-cycle check failed");
`else
`define KPD_ASSERT_IMP(label, clk, rstn, ante, cons)
`define KPD_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: src/kpd_pkg.sv
`default_nettype none
package kpd_pkg;

    localparam int KPD_MAX_DIGITS = 8;

    localparam logic [4:0] NO_KEY = 5'd16;

    localparam logic [6:0] CHAR_STAR = 7'h2A;
    localparam logic [6:0] CHAR_HASH = 7'h23;
    localparam logic [6:0] CHAR_ZERO = 7'h30;
    localparam logic [6:0] CHAR_NINE = 7'h39;

    localparam logic [15:0] DEBOUNCE_RST   = 16'd30;
    localparam logic [31:0] TIMEOUT_RST    = 32'd10000;
    localparam logic [3:0]  PIN_MIN_RST    = 4'd4;
    localparam logic [3:0]  PIN_MAX_RST    = 4'd8;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_TIMEOUT  = 2'd1,
        CFG_PIN_MIN  = 2'd2,
        CFG_PIN_MAX  = 2'd3
    } kpd_cfg_idx_t;

    // debounced key event handed to the entry logic
    typedef struct packed {
        logic        fire;
        logic        locked;
        logic        clr;
        logic [6:0]  ch;
        logic [31:0] now;
    } kpd_key_evt_t;

    typedef struct packed {
        logic        pin_valid;
        logic [3:0]  pin_length;
        logic [31:0] pin_digits;
        logic [3:0]  entry_length;
        logic [31:0] entry_digits;
    } kpd_entry_res_t;

    // lowest set bit wins, NO_KEY when nothing pressed
    function automatic logic [4:0] first_key(input logic [15:0] keys);
        logic [4:0] k;
        k = NO_KEY;
        for (int i = 15; i >= 0; i--) begin
            if (keys[i]) begin
                k = 5'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [6:0] key_ascii(input logic [3:0] idx);
        logic [6:0] c;
        unique case (idx)
            4'd0:  c = 7'h31;
            4'd1:  c = 7'h32;
            4'd2:  c = 7'h33;
            4'd3:  c = 7'h41;
            4'd4:  c = 7'h34;
            4'd5:  c = 7'h35;
            4'd6:  c = 7'h36;
            4'd7:  c = 7'h42;
            4'd8:  c = 7'h37;
            4'd9:  c = 7'h38;
            4'd10: c = 7'h39;
            4'd11: c = 7'h43;
            4'd12: c = CHAR_STAR;
            4'd13: c = CHAR_ZERO;
            4'd14: c = CHAR_HASH;
            4'd15: c = 7'h44;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: src/kpd_entry.sv
`default_nettype none
// PIN entry store: clears, idle timeout, digit append, PIN completion.
module kpd_entry
    import kpd_pkg::*;
#(
    parameter int MAX_DIGITS = KPD_MAX_DIGITS
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire kpd_key_evt_t   evt,
    input  wire logic [31:0]    timeout_ms,
    input  wire logic [3:0]     len_min,
    input  wire logic [3:0]     len_max,
    output kpd_entry_res_t      res
);

    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int CMP_W  = (CNT_W > 4) ? CNT_W : 4;
    localparam int PACK_N = (MAX_DIGITS < 8) ? MAX_DIGITS : 8;

    logic [3:0]       store_reg [MAX_DIGITS];
    logic [3:0]       store_b   [MAX_DIGITS];
    logic [3:0]       store_next[MAX_DIGITS];
    logic [CNT_W-1:0] count_reg, count_next, cnt_b;
    logic [31:0]      last_time_reg, last_time_next, last_b, idle;
    logic             timing_reg, timing_next, tim_b;

    logic             wipe_a, wipe_b, wipe_c, timed_out;
    logic             active, is_star, is_hash, is_digit, pin_ok, append;
    logic [CMP_W-1:0] cnt_cmp;

    // first eight digits, unused nibbles zero
    function automatic logic [31:0] pack(input logic [3:0] st [MAX_DIGITS],
                                         input logic [CNT_W-1:0] n);
        logic [31:0] v;
        v = '0;
        for (int i = 0; i < PACK_N; i++) begin
            if (CNT_W'(i) < n) begin
                v[4*i +: 4] = st[i];
            end
        end
        return v;
    endfunction

    always_comb begin
        wipe_a    = evt.clr || evt.locked;
        idle      = evt.now - last_time_reg;
        timed_out = !evt.locked && !wipe_a && (count_reg != '0) && timing_reg
                    && (idle > timeout_ms);
        wipe_b    = wipe_a || timed_out;

        cnt_b  = wipe_b ? '0 : count_reg;
        tim_b  = wipe_b ? 1'b0 : timing_reg;
        last_b = wipe_b ? '0 : last_time_reg;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            store_b[i] = wipe_b ? 4'd0 : store_reg[i];
        end

        active   = evt.fire && !evt.locked;
        is_star  = (evt.ch == CHAR_STAR);
        is_hash  = (evt.ch == CHAR_HASH);
        is_digit = (evt.ch >= CHAR_ZERO) && (evt.ch <= CHAR_NINE);
        cnt_cmp  = CMP_W'(cnt_b);

        // upper bound uncapped here, as for the PIN check
        pin_ok = active && is_hash && (cnt_cmp >= CMP_W'(len_min))
                 && (cnt_cmp <= CMP_W'(len_max));
        append = active && is_digit && (cnt_cmp < CMP_W'(len_max))
                 && (cnt_cmp < CMP_W'(MAX_DIGITS));
        wipe_c = active && (is_star || is_hash);

        count_next     = wipe_c ? '0 : (append ? cnt_b + CNT_W'(1) : cnt_b);
        timing_next    = wipe_c ? 1'b0 : (append ? 1'b1 : tim_b);
        last_time_next = wipe_c ? '0 : (append ? evt.now : last_b);
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (wipe_c) begin
                store_next[i] = 4'd0;
            end else if (append && (cnt_b == CNT_W'(i))) begin
                store_next[i] = evt.ch[3:0];
            end else begin
                store_next[i] = store_b[i];
            end
        end

        res.pin_valid    = pin_ok;
        res.pin_length   = pin_ok ? 4'(cnt_b) : 4'd0;
        res.pin_digits   = pin_ok ? pack(store_b, cnt_b) : 32'd0;
        res.entry_length = 4'(count_next);
        res.entry_digits = pack(store_next, count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            timing_reg    <= 1'b0;
            last_time_reg <= '0;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                store_reg[i] <= 4'd0;
            end
        end else if (en) begin
            count_reg     <= count_next;
            timing_reg    <= timing_next;
            last_time_reg <= last_time_next;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                store_reg[i] <= store_next[i];
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/keypad_debounce_pin_entry.sv
`default_nettype none
// Channel   Dir  Handshake          Payload
// s_ poll   in   s_valid / s_ready  pressed_keys, now_ms, locked_out, clear_request
// m_ result out  m_valid / m_ready  key_valid, key_char, pin_valid, pin_length,
//                                   pin_digits, entry_length, entry_digits
// cfg       in   cfg_we             cfg_addr, cfg_wdata
//
// One poll word per clock sustained while m_ready holds; a word passes from the input register
// into the result register and from there appears at m_.
// Debounce and entry state advance only when a word moves from the input
// register into the result register, so a stalled m_ side freezes them.
// Synchronous active-low reset returns config to defaults and clears all state.
// s_ready stays high while the result register is empty or being drained.
`include "keypad_debounce_pin_entry_assert.svh"
module keypad_debounce_pin_entry
    import kpd_pkg::*;
#(
    parameter int MAX_DIGITS = KPD_MAX_DIGITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_pressed_keys,
    input  wire logic [31:0] s_now_ms,
    input  wire logic        s_locked_out,
    input  wire logic        s_clear_request,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_key_valid,
    output logic [6:0]       m_key_char,
    output logic             m_pin_valid,
    output logic [3:0]       m_pin_length,
    output logic [31:0]      m_pin_digits,
    output logic [3:0]       m_entry_length,
    output logic [31:0]      m_entry_digits
);

    // config registers
    logic [15:0] debounce_reg;
    logic [31:0] timeout_reg;
    logic [3:0]  pin_min_reg, pin_max_reg;

    // input register
    logic        in_valid_reg;
    logic [15:0] in_keys_reg;
    logic [31:0] in_now_reg;
    logic        in_locked_reg, in_clr_reg;

    // debounce state
    logic [4:0]  last_raw_reg, stable_reg;
    logic [31:0] change_time_reg;

    // result register
    logic        out_valid_reg;
    logic        out_key_valid_reg;
    logic [6:0]  out_key_char_reg;
    kpd_entry_res_t out_res_reg;

    logic           advance;
    logic [4:0]     raw;
    logic [31:0]    change_time_next, held;
    logic           fire_cand, key_fire;
    logic [6:0]     ch;
    kpd_key_evt_t   evt;
    kpd_entry_res_t entry_res;
    logic           hash_done;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RST;
            timeout_reg  <= TIMEOUT_RST;
            pin_min_reg  <= PIN_MIN_RST;
            pin_max_reg  <= PIN_MAX_RST;
        end else if (cfg_we) begin
            unique case (kpd_cfg_idx_t'(cfg_addr))
                CFG_DEBOUNCE: debounce_reg <= cfg_wdata[15:0];
                CFG_TIMEOUT:  timeout_reg  <= cfg_wdata;
                CFG_PIN_MIN:  pin_min_reg  <= cfg_wdata[3:0];
                CFG_PIN_MAX:  pin_max_reg  <= cfg_wdata[3:0];
            endcase
        end
    end

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_keys_reg   <= s_pressed_keys;
            in_now_reg    <= s_now_ms;
            in_locked_reg <= s_locked_out;
            in_clr_reg    <= s_clear_request;
        end
    end

    // Debounce: raw key must sit unchanged for debounce_ms; a change restarts
    // the hold from this poll's timestamp (zero hold accepts at once).
    always_comb begin
        raw              = first_key(in_keys_reg);
        change_time_next = (raw != last_raw_reg) ? in_now_reg : change_time_reg;
        held             = in_now_reg - change_time_next;
        fire_cand        = (held >= {16'd0, debounce_reg}) && (stable_reg != raw);
        key_fire         = fire_cand && (raw != NO_KEY);
        ch               = key_fire ? key_ascii(raw[3:0]) : 7'd0;

        evt.fire   = key_fire;
        evt.locked = in_locked_reg;
        evt.clr    = in_clr_reg;
        evt.ch     = ch;
        evt.now    = in_now_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg    <= NO_KEY;
            stable_reg      <= NO_KEY;
            change_time_reg <= '0;
        end else if (advance) begin
            last_raw_reg    <= raw;
            change_time_reg <= change_time_next;
            if (fire_cand) begin
                stable_reg <= raw;
            end
        end
    end

    kpd_entry #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_entry (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .evt         (evt),
        .timeout_ms  (timeout_reg),
        .len_min     (pin_min_reg),
        .len_max     (pin_max_reg),
        .res         (entry_res)
    );

    // Result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_key_valid_reg <= key_fire;
            out_key_char_reg  <= ch;
            out_res_reg       <= entry_res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_key_valid    = out_key_valid_reg;
    assign m_key_char     = out_key_char_reg;
    assign m_pin_valid    = out_res_reg.pin_valid;
    assign m_pin_length   = out_res_reg.pin_length;
    assign m_pin_digits   = out_res_reg.pin_digits;
    assign m_entry_length = out_res_reg.entry_length;
    assign m_entry_digits = out_res_reg.entry_digits;

    // fresh '#' with the entry left empty
    assign hash_done = m_key_valid && (m_key_char == CHAR_HASH) && (m_entry_length == 4'd0);

    // a completed PIN only ever comes from a fresh '#' and leaves the entry empty
    `KPD_ASSERT_IMP(a_pin_from_hash, aclk, aresetn, m_valid && m_pin_valid, hash_done)
    // input side stalls only behind a full, stalled result register
    `KPD_ASSERT_IMP(a_ready_stall, aclk, aresetn, !s_ready, in_valid_reg && out_valid_reg && !m_ready)
    // every word that leaves the input stage shows up as a result
    `KPD_ASSERT_NXT(a_advance_out, aclk, aresetn, advance, m_valid)
    // no key, no character
    `KPD_ASSERT_IMP(a_char_zero, aclk, aresetn, m_valid && !m_key_valid, m_key_char == 7'd0)

endmodule
`default_nettype wire

FILE: test/keypad_debounce_pin_entry_test.sv
module keypad_debounce_pin_entry_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kpd_pkg::*;

    // One poll word as it crosses the s_ channel.
    typedef struct packed {
        logic [15:0] keys;
        logic [31:0] now;
        logic        locked;
        logic        clr;
    } poll_word_t;

    // One result word as it leaves on the m_ channel.
    typedef struct packed {
        logic        key_valid;
        logic [6:0]  key_char;
        logic        pin_valid;
        logic [3:0]  pin_length;
        logic [31:0] pin_digits;
        logic [3:0]  entry_length;
        logic [31:0] entry_digits;
    } key_report_t;

    // Directed script row: a poll, and where 'typed' is set the result written out by hand.
    typedef struct packed {
        logic [15:0] keys;
        logic [31:0] now;
        logic        locked;
        logic        clr;
        logic        typed;
        key_report_t want;
    } script_row_t;

    localparam int SCRIPT_ROWS = 26;
    localparam int PHASES      = 8;
    localparam int PHASE_POLLS = 210;
    localparam int LONG_HOLD   = 60;     // receiver hold-off, in cycles
    localparam int MAX_PRINTS  = 100;    // keeps the log short on a badly broken build

    // Key legend, row-major, bit row*4+col.
    localparam logic [6:0] KEY_LEGEND [16] = '{
        7'h31, 7'h32, 7'h33, 7'h41,
        7'h34, 7'h35, 7'h36, 7'h42,
        7'h37, 7'h38, 7'h39, 7'h43,
        7'h2A, 7'h30, 7'h23, 7'h44
    };

    // Bit positions of the digit keys and the two control keys.
    localparam int DIGIT_BITS [10] = '{0, 1, 2, 4, 5, 6, 8, 9, 10, 13};
    localparam int KEY_STAR_BIT = 12;
    localparam int KEY_HASH_BIT = 14;

    // Idling per mode: sender idle and receiver stall, percent of cycles.
    localparam int SEND_IDLE  [4] = '{0, 68, 0, 12};
    localparam int RECV_STALL [4] = '{0, 0, 68, 12};

    localparam kpd_cfg_idx_t REG_ORDER [4] = '{CFG_DEBOUNCE, CFG_TIMEOUT, CFG_PIN_MIN, CFG_PIN_MAX};

    // Register sets per phase, in REG_ORDER: debounce, timeout, min length, max length.
    localparam logic [31:0] REG_SETS [PHASES][4] = '{
        '{32'd30,        32'd10000,     32'd4,         32'd8},         // reset values
        '{32'd0,         32'd0,         32'd0,         32'd0},         // all at zero
        '{32'd65535,     32'hFFFF_FFFF, 32'd8,         32'd8},         // all at top
        '{32'd5,         32'd200,       32'd1,         32'd15},        // max beyond capacity
        '{32'd20,        32'd1000,      32'd6,         32'd3},         // min above max
        '{32'd1,         32'd50,        32'd0,         32'd4},         // min zero
        '{32'hFFFF_000A, 32'd500,       32'hFFFF_FFF2, 32'h0000_00F5}, // upper bits dropped
        '{32'd30,        32'd10000,     32'd4,         32'd8}          // back to reset, clock wraps
    };

    // Directed script, reset register values throughout (debounce 30, timeout 10000, 4..8).
    localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
        // nothing pressed straight after reset
        '{16'h0000, 32'd0,     1'b0, 1'b0, 1'b1, '{1'b0, 7'h00, 1'b0, 4'd0, 32'h0, 4'd0, 32'h0}},
        // '1' pressed, then held for exactly the debounce time
        '{16'h0001, 32'd100,   1'b0, 1'b0, 1'b0, '0},
        '{16'h0001, 32'd130,   1'b0, 1'b0, 1'b1, '{1'b1, 7'h31, 1'b0, 4'd0, 32'h0, 4'd1, 32'h1}},
        // every key at once: lowest bit still '1', already settled
        '{16'hFFFF, 32'd140,   1'b0, 1'b0, 1'b0, '0},
        '{16'h0002, 32'd150,   1'b0, 1'b0, 1'b0, '0},
        '{16'h0002, 32'd180,   1'b0, 1'b0, 1'b0, '0},
        '{16'h0004, 32'd190,   1'b0, 1'b0, 1'b0, '0},
        '{16'h0004, 32'd220,   1'b0, 1'b0, 1'b0, '0},
        '{16'h2000, 32'd230,   1'b0, 1'b0, 1'b0, '0},
        '{16'h2000, 32'd260,   1'b0, 1'b0, 1'b0, '0},
        // '#' with four digits held: PIN out, entry cleared
        '{16'h4000, 32'd270,   1'b0, 1'b0, 1'b0, '0},
        '{16'h4000, 32'd300,   1'b0, 1'b0, 1'b0, '0},
        // top key 'D': reported, otherwise ignored
        '{16'h8000, 32'd310,   1'b0, 1'b0, 1'b0, '0},
        '{16'h8000, 32'd340,   1'b0, 1'b0, 1'b1, '{1'b1, 7'h44, 1'b0, 4'd0, 32'h0, 4'd0, 32'h0}},
        // '4' under lockout: key reported, entry untouched
        '{16'h0010, 32'd350,   1'b1, 1'b0, 1'b0, '0},
        '{16'h0010, 32'd380,   1'b1, 1'b0, 1'b1, '{1'b1, 7'h34, 1'b0, 4'd0, 32'h0, 4'd0, 32'h0}},
        // '5' stored, then a clear request wipes it
        '{16'h0020, 32'd400,   1'b0, 1'b0, 1'b0, '0},
        '{16'h0020, 32'd430,   1'b0, 1'b0, 1'b0, '0},
        '{16'h0020, 32'd440,   1'b0, 1'b1, 1'b0, '0},
        // '6' stored, then '*' wipes it
        '{16'h0040, 32'd450,   1'b0, 1'b0, 1'b0, '0},
        '{16'h0040, 32'd480,   1'b0, 1'b0, 1'b0, '0},
        '{16'h1000, 32'd490,   1'b0, 1'b0, 1'b0, '0},
        '{16'h1000, 32'd520,   1'b0, 1'b0, 1'b0, '0},
        // '7' stored, then idle one past the timeout
        '{16'h0100, 32'd530,   1'b0, 1'b0, 1'b0, '0},
        '{16'h0100, 32'd560,   1'b0, 1'b0, 1'b0, '0},
        '{16'h0100, 32'd10561, 1'b0, 1'b0, 1'b0, '0}
    };

    // ---------------------------------------------------------------------------------
    // Block ports
    // ---------------------------------------------------------------------------------
    logic         aclk            = 1'b0;
    logic         aresetn         = 1'b0;
    logic         cfg_we          = 1'b0;
    kpd_cfg_idx_t cfg_addr        = CFG_DEBOUNCE;
    logic [31:0]  cfg_wdata       = '0;
    logic         s_valid         = 1'b0;
    logic         s_ready;
    logic [15:0]  s_pressed_keys  = '0;
    logic [31:0]  s_now_ms        = '0;
    logic         s_locked_out    = 1'b0;
    logic         s_clear_request = 1'b0;
    logic         m_valid;
    logic         m_ready         = 1'b0;
    logic         m_key_valid;
    logic [6:0]   m_key_char;
    logic         m_pin_valid;
    logic [3:0]   m_pin_length;
    logic [31:0]  m_pin_digits;
    logic [3:0]   m_entry_length;
    logic [31:0]  m_entry_digits;

    keypad_debounce_pin_entry u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pressed_keys  (s_pressed_keys),
        .s_now_ms        (s_now_ms),
        .s_locked_out    (s_locked_out),
        .s_clear_request (s_clear_request),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_key_valid     (m_key_valid),
        .m_key_char      (m_key_char),
        .m_pin_valid     (m_pin_valid),
        .m_pin_length    (m_pin_length),
        .m_pin_digits    (m_pin_digits),
        .m_entry_length  (m_entry_length),
        .m_entry_digits  (m_entry_digits)
    );

    // 8 ns clock.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---------------------------------------------------------------------------------
    // Local copy of the poller: registers and state, initialised to their reset values
    // ---------------------------------------------------------------------------------
    logic [15:0] set_debounce_ms = DEBOUNCE_RST;
    logic [31:0] set_timeout_ms  = TIMEOUT_RST;
    logic [3:0]  set_min_len     = PIN_MIN_RST;
    logic [3:0]  set_max_len     = PIN_MAX_RST;

    logic [4:0]  raw_key_seen    = NO_KEY;
    logic [4:0]  settled_key     = NO_KEY;
    logic [31:0] raw_since_ms    = '0;
    logic [31:0] entry_word      = '0;    // digits packed, first in the lowest nibble
    int          entry_count     = 0;
    logic [31:0] last_digit_ms   = '0;
    logic        idle_armed      = 1'b0;

    key_report_t decoded_polls [$];       // results owed by the block, oldest first
    key_report_t oldest;
    int          mismatch_count  = 0;
    int          send_idle_pct   = 0;
    int          recv_stall_pct  = 0;
    int          hold_off_token  = 0;     // bumped to ask the receiver for a long hold-off

    function automatic void clear_entry();
        entry_word    = '0;
        entry_count   = 0;
        last_digit_ms = '0;
        idle_armed    = 1'b0;
    endfunction

    // Advances the local copy by one poll and returns the result word it gives.
    function automatic key_report_t decode_poll(input poll_word_t p);
        key_report_t r;
        logic [4:0]  raw;
        logic [6:0]  ch;
        logic [31:0] since_digit;
        logic [31:0] since_change;
        int          cap;
        r   = '0;
        raw = NO_KEY;

        // clear request and lockout both wipe before anything else
        if (p.clr || p.locked) begin
            clear_entry();
        end
        since_digit = p.now - last_digit_ms;
        if (!p.locked && entry_count != 0 && idle_armed && since_digit > set_timeout_ms) begin
            clear_entry();
        end

        // lowest pressed bit wins
        for (int i = 0; i < 16; i++) begin
            if (p.keys[i] && raw == NO_KEY) begin
                raw = 5'(i);
            end
        end
        if (raw != raw_key_seen) begin
            raw_key_seen = raw;
            raw_since_ms = p.now;
        end

        since_change = p.now - raw_since_ms;
        if (since_change >= 32'(set_debounce_ms) && settled_key != raw) begin
            settled_key = raw;
            if (raw != NO_KEY) begin
                ch          = KEY_LEGEND[raw[3:0]];
                r.key_valid = 1'b1;
                r.key_char  = ch;
                if (!p.locked) begin
                    cap = (set_max_len < KPD_MAX_DIGITS) ? int'(set_max_len) : KPD_MAX_DIGITS;
                    if (ch == CHAR_STAR) begin
                        clear_entry();
                    end else if (ch == CHAR_HASH) begin
                        // length checked against the uncapped maximum
                        if (entry_count >= set_min_len && entry_count <= set_max_len) begin
                            r.pin_valid  = 1'b1;
                            r.pin_length = 4'(entry_count);
                            r.pin_digits = entry_word;
                        end
                        clear_entry();
                    end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE && entry_count < cap) begin
                        entry_word[4*entry_count +: 4] = 4'(ch - CHAR_ZERO);
                        entry_count++;
                        last_digit_ms = p.now;
                        idle_armed    = 1'b1;
                    end
                end
            end
        end

        r.entry_length = 4'(entry_count);
        r.entry_digits = entry_word;
        return r;
    endfunction

    // ---------------------------------------------------------------------------------
    // Mismatch reporting
    // ---------------------------------------------------------------------------------
    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("%0t ns  result mismatch: %s", $realtime, what);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            note_mismatch($sformatf("%s got %h, want %h", name, got, want));
        end
    endtask

    // ---------------------------------------------------------------------------------
    // Register writes, only while the block is idle
    // ---------------------------------------------------------------------------------
    task automatic load_settings(input int set_no);
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= REG_ORDER[i];
            cfg_wdata <= REG_SETS[set_no][i];
            case (REG_ORDER[i])
                CFG_DEBOUNCE: set_debounce_ms = REG_SETS[set_no][i][15:0];
                CFG_TIMEOUT:  set_timeout_ms  = REG_SETS[set_no][i];
                CFG_PIN_MIN:  set_min_len     = REG_SETS[set_no][i][3:0];
                CFG_PIN_MAX:  set_max_len     = REG_SETS[set_no][i][3:0];
                default: ;
            endcase
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------------------------
    // Sender: called at a falling edge, returns at the falling edge after the word
    // has been taken. Gaps only come before valid rises; once up it holds.
    // ---------------------------------------------------------------------------------
    task automatic offer_poll(input poll_word_t p, input logic given, input key_report_t want);
        key_report_t r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_pressed_keys  <= p.keys;
        s_now_ms        <= p.now;
        s_locked_out    <= p.locked;
        s_clear_request <= p.clr;
        @(posedge aclk);
        while (s_ready !== 1'b1) begin
            @(posedge aclk);
        end
        // word taken at this edge; the local copy moves on by the same poll
        r = decode_poll(p);
        decoded_polls.push_back(given ? want : r);
        @(negedge aclk);
    endtask

    // ---------------------------------------------------------------------------------
    // Receiver: random stalls per mode, plus a long hold-off on request, counted here
    // ---------------------------------------------------------------------------------
    initial begin
        int hold_left;
        int token_seen;
        hold_left  = 0;
        token_seen = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_token != token_seen) begin
                token_seen = hold_off_token;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Result check, sampled at the rising edge before the block updates.
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (decoded_polls.size() == 0) begin
                note_mismatch("result word with nothing outstanding");
            end else begin
                oldest = decoded_polls.pop_front();
                compare_field("key_valid",    m_key_valid,    oldest.key_valid);
                compare_field("key_char",     m_key_char,     oldest.key_char);
                compare_field("pin_valid",    m_pin_valid,    oldest.pin_valid);
                compare_field("pin_length",   m_pin_length,   oldest.pin_length);
                compare_field("pin_digits",   m_pin_digits,   oldest.pin_digits);
                compare_field("entry_length", m_entry_length, oldest.entry_length);
                compare_field("entry_digits", m_entry_digits, oldest.entry_digits);
            end
        end
    end

    // Hard stop, far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------------------
    initial begin
        poll_word_t  p;
        script_row_t row;
        int          n_done;
        int          sel;
        int          hold_n;
        int          rel_n;
        logic [15:0] press_map;
        logic [31:0] step;
        logic [31:0] poll_clock;

        // reset held low, then released on a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed script, no idling
        for (int i = 0; i < SCRIPT_ROWS; i++) begin
            row = SCRIPT[i];
            p   = '{row.keys, row.now, row.locked, row.clr};
            offer_poll(p, row.typed, row.want);
        end
        s_valid <= 1'b0;
        while (decoded_polls.size() != 0) begin
            @(negedge aclk);
        end
        poll_clock = 32'd20000;

        for (int ph = 0; ph < PHASES; ph++) begin
            // all results drained, nothing still in flight; a pause before the writes
            repeat (4) @(negedge aclk);
            load_settings(ph);
            send_idle_pct  = SEND_IDLE[ph % 4];
            recv_stall_pct = RECV_STALL[ph % 4];
            if (ph == 0) begin
                // receiver stops for a long stretch while polls keep coming
                hold_off_token++;
            end
            if (ph == PHASES - 1) begin
                // timestamps run through the 32-bit wrap
                poll_clock = 32'hFFFF_F000;
            end

            n_done = 0;
            while (n_done < PHASE_POLLS) begin
                // one key press: held for one to six polls, then released for one to four
                sel = $urandom_range(0, 99);
                if (sel < 55) begin
                    press_map = 16'h1 << DIGIT_BITS[$urandom_range(0, 9)];
                end else if (sel < 67) begin
                    press_map = 16'h1 << KEY_HASH_BIT;
                end else if (sel < 75) begin
                    press_map = 16'h1 << KEY_STAR_BIT;
                end else if (sel < 82) begin
                    press_map = 16'h1 << (3 + 4 * $urandom_range(0, 3));   // A to D
                end else begin
                    press_map = 16'($urandom());                           // several keys
                end
                hold_n = $urandom_range(1, 6);
                rel_n  = $urandom_range(1, 4);

                for (int j = 0; j < hold_n + rel_n; j++) begin
                    p.keys = (j < hold_n) ? press_map : 16'h0000;
                    if ($urandom_range(0, 99) < 6) begin
                        p.keys = 16'($urandom());    // contact bounce
                    end
                    // steps of a third to half the debounce hold (plus two), so held presses can settle
                    step = $urandom_range(set_debounce_ms / 3, set_debounce_ms / 2 + 2);
                    if ($urandom_range(0, 99) < 4) begin
                        // long pause around the idle timeout
                        step += set_timeout_ms / 2 + $urandom_range(0, set_timeout_ms / 2 + 1);
                    end
                    poll_clock += step;
                    p.now    = poll_clock;
                    p.locked = ($urandom_range(0, 99) < 4);
                    p.clr    = ($urandom_range(0, 99) < 3);
                    offer_poll(p, 1'b0, '0);
                    n_done++;
                end
            end

            s_valid <= 1'b0;
            while (decoded_polls.size() != 0) begin
                @(negedge aclk);
            end
        end

        repeat (4) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
